@@ rtl/clipped_rect_framebuffer_write_top_macros.svh @@
// Assertion macros used by crfw_coord.
`ifndef CLIPPED_RECT_FRAMEBUFFER_WRITE_TOP_MACROS_SVH
`define CLIPPED_RECT_FRAMEBUFFER_WRITE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CRFW_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crfw assertion failed");
`define CRFW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crfw assertion failed");
`else
`define CRFW_ASSERT(lbl, ante, cons)
`define CRFW_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/crfw_pkg.sv @@
package crfw_pkg;

  localparam int CntW = 11;
  localparam int PosW = 12;
  localparam int CrdW = 13;
  localparam int IdxW = 19;
  localparam int PixW = 32;

  localparam logic [CntW-1:0] CntMax = '1;

  typedef struct packed {
    logic [CntW-1:0] sx;
    logic [CntW-1:0] sy;
    logic [PixW-1:0] pixel;
  } crd_t;

endpackage

@@ rtl/crfw_intf.sv @@
interface crfw_pix_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  first_pixel;
  logic signed [crfw_pkg::PosW-1:0]      rect_x;
  logic signed [crfw_pkg::PosW-1:0]      rect_y;
  logic        [crfw_pkg::CntW-1:0]      rect_w;
  logic        [crfw_pkg::CntW-1:0]      rect_h;
  logic        [crfw_pkg::PixW-1:0]      pixel_value;

  modport source (output valid, first_pixel, rect_x, rect_y, rect_w, rect_h, pixel_value,
                  input ready);
  modport sink   (input valid, first_pixel, rect_x, rect_y, rect_w, rect_h, pixel_value,
                  output ready);
endinterface

interface crfw_wr_if;
  logic                          valid;
  logic                          ready;
  logic [crfw_pkg::IdxW-1:0]     fb_word_index;
  logic [crfw_pkg::PixW-1:0]     pixel_out;

  modport source (output valid, fb_word_index, pixel_out, input ready);
  modport sink   (input valid, fb_word_index, pixel_out, output ready);
endinterface

@@ rtl/clipped_rect_framebuffer_write_top.sv @@
// A request that lands on screen has its write registered in crfw_coord, then in crfw_addr.
// Throughput: one request per cycle while wr_o is ready; set by the clip stage
// and the index multiply-add stage, each with a single register slot.
// Requests off screen, outside the rectangle or with zero size give no write.
// Reset (async, active low) clears the column/row counters and both valid flags.
module clipped_rect_framebuffer_write_top #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crfw_pix_if.sink   pix_i,
  crfw_wr_if.source  wr_o
);
  import crfw_pkg::*;

  crd_t crd;
  logic crd_valid, crd_ready;

  crfw_coord #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_coord (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .crd_o       (crd),
    .crd_valid_o (crd_valid),
    .crd_ready_i (crd_ready)
  );

  crfw_addr #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_addr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .crd_i       (crd),
    .crd_valid_i (crd_valid),
    .crd_ready_o (crd_ready),
    .wr_o        (wr_o)
  );

endmodule

@@ rtl/crfw_coord.sv @@
`include "clipped_rect_framebuffer_write_top_macros.svh"

module crfw_coord #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  crfw_pix_if.sink        pix_i,
  output crfw_pkg::crd_t  crd_o,
  output logic            crd_valid_o,
  input  logic            crd_ready_i
);
  import crfw_pkg::*;

  localparam logic [CrdW-1:0] ScrW = CrdW'(SCREEN_WIDTH);
  localparam logic [CrdW-1:0] ScrH = CrdW'(SCREEN_HEIGHT);

  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic [CntW-1:0] col_base, row_base;
  logic [CntW:0]   col_inc;
  logic [CrdW-1:0] sx, sy;
  logic            accept, skip, on_screen, crd_valid_q;
  crd_t            crd_q;

  assign pix_i.ready = !crd_valid_q || crd_ready_i;
  assign accept      = pix_i.valid && pix_i.ready;

  assign col_base = pix_i.first_pixel ? '0 : col_q;
  assign row_base = pix_i.first_pixel ? '0 : row_q;
  assign skip     = (pix_i.rect_w == '0) || (pix_i.rect_h == '0) || (row_base >= pix_i.rect_h);

  assign sx = {pix_i.rect_x[PosW-1], pix_i.rect_x} + {2'b00, col_base};
  assign sy = {pix_i.rect_y[PosW-1], pix_i.rect_y} + {2'b00, row_base};
  assign on_screen = !sx[CrdW-1] && (sx < ScrW) && !sy[CrdW-1] && (sy < ScrH);

  assign col_inc = {1'b0, col_base} + {{CntW{1'b0}}, 1'b1};

  always_comb begin
    col_d = col_base;
    row_d = row_base;
    if (!skip) begin
      if (col_inc >= {1'b0, pix_i.rect_w}) begin
        col_d = '0;
        if (row_base < CntMax) begin
          row_d = row_base + {{(CntW-1){1'b0}}, 1'b1};
        end
      end else begin
        col_d = col_inc[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      crd_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (pix_i.ready) begin
        crd_valid_q <= accept && !skip && on_screen;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.ready) begin
      crd_q.sx    <= sx[CntW-1:0];
      crd_q.sy    <= sy[CntW-1:0];
      crd_q.pixel <= pix_i.pixel_value;
    end
  end

  assign crd_o       = crd_q;
  assign crd_valid_o = crd_valid_q;

  `CRFW_ASSERT_NXT(a_first_empty_clears, accept && pix_i.first_pixel && (pix_i.rect_w == '0), (col_q == '0) && (row_q == '0))
  `CRFW_ASSERT_NXT(a_row_step, accept && !pix_i.first_pixel, (row_q == $past(row_q)) || (row_q == $past(row_q) + 1'b1))
  `CRFW_ASSERT_NXT(a_stall_holds, crd_valid_q && !crd_ready_i, crd_valid_q && $stable(crd_q))
  `CRFW_ASSERT(a_hit_on_screen, crd_valid_q, (crd_q.sx < ScrW[CntW-1:0]) || (ScrW[CntW]))

endmodule

@@ rtl/crfw_addr.sv @@
module crfw_addr #(
  parameter int SCREEN_WIDTH = 640
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crfw_pkg::crd_t  crd_i,
  input  logic            crd_valid_i,
  output logic            crd_ready_o,
  crfw_wr_if.source       wr_o
);
  import crfw_pkg::*;

  localparam logic [CntW-1:0] ScrW = CntW'(SCREEN_WIDTH);

  logic [2*CntW-1:0] prod;
  logic [2*CntW:0]   sum;
  logic              valid_q;
  logic [IdxW-1:0]   idx_q;
  logic [PixW-1:0]   pix_q;

  assign crd_ready_o = !valid_q || wr_o.ready;

  assign prod = {{CntW{1'b0}}, crd_i.sy} * {{CntW{1'b0}}, ScrW};
  assign sum  = {1'b0, prod} + {{(CntW+1){1'b0}}, crd_i.sx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (crd_ready_o) begin
      valid_q <= crd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (crd_ready_o) begin
      idx_q <= sum[IdxW-1:0];
      pix_q <= crd_i.pixel;
    end
  end

  assign wr_o.valid         = valid_q;
  assign wr_o.fb_word_index = idx_q;
  assign wr_o.pixel_out     = pix_q;

endmodule
